>>> design/hed_pkg.sv
// Shared types, codes and functions of the HTML entity to UTF-8 decoder.
// No dependencies; every other file but hed_if imports this package.
package hed_pkg;

   localparam int NAME_MAX_DEF = 16;
   localparam int LEN_W = 7;
   localparam logic [15:0] LIMIT_RST = 16'd1024;

   localparam logic [2:0] EK_NONE    = 3'd0;
   localparam logic [2:0] EK_BYTE    = 3'd1;
   localparam logic [2:0] EK_AMPHASH = 3'd2;
   localparam logic [2:0] EK_CODE    = 3'd3;
   localparam logic [2:0] EK_ECHO    = 3'd4;

   localparam logic [7:0] CH_QUOT = 8'd34;
   localparam logic [7:0] CH_AMP  = 8'd38;
   localparam logic [7:0] CH_LT   = 8'd60;
   localparam logic [7:0] CH_GT   = 8'd62;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3b;

   typedef struct packed {
      logic [2:0]       ekind;
      logic [7:0]       ebyte;
      logic [31:0]      code;
      logic [LEN_W-1:0] elen;
      logic             thas;
      logic [7:0]       tbyte;
      logic             last;
   } desc_type;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic [2:0] utf8_len(input logic [31:0] u);
      logic [2:0] n;
      if (u[31]) begin
         n = (u[7:0] != 8'd0) ? 3'd1 : 3'd0;
      end else if (u == 32'd0) begin
         n = 3'd0;
      end else if (u <= 32'h7f) begin
         n = 3'd1;
      end else if (u <= 32'h7ff) begin
         n = 3'd2;
      end else if (u <= 32'hffff) begin
         n = 3'd3;
      end else if (u <= 32'h1fffff) begin
         n = 3'd4;
      end else if (u <= 32'h3ffffff) begin
         n = 3'd5;
      end else begin
         n = 3'd6;
      end
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [31:0] u, input logic [2:0] len,
                                            input logic [2:0] idx);
      logic [2:0]  rem;
      logic [4:0]  sh;
      logic [31:0] part;
      logic [7:0]  lead;
      logic [7:0]  res;
      rem  = 3'(len - 3'd1 - idx);
      sh   = 5'({2'b00, rem} * 5'd6);
      part = u >> sh;
      case (len)
         3'd2: begin
            lead = 8'hc0;
         end
         3'd3: begin
            lead = 8'he0;
         end
         3'd4: begin
            lead = 8'hf0;
         end
         3'd5: begin
            lead = 8'hf8;
         end
         3'd6: begin
            lead = 8'hfc;
         end
         default: begin
            lead = 8'h00;
         end
      endcase
      if (len == 3'd1) begin
         res = u[7:0];
      end else if (idx == 3'd0) begin
         res = lead | part[7:0];
      end else begin
         res = 8'h80 | {2'b00, part[5:0]};
      end
      return res;
   endfunction

endpackage

>>> design/hed_if.sv
// Request, response and register-write channel interfaces of the decoder.
// Depends on nothing; the top level uses all three.
interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       run_last;
   logic       text_end;
   modport source (output valid, output out_byte, output out_valid, output run_last,
                   output text_end, input ready);
   modport sink (input valid, input out_byte, input out_valid, input run_last,
                 input text_end, output ready);
endinterface

interface hed_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] output_limit;
   modport source (output valid, output output_limit, input ready);
   modport sink (input valid, input output_limit, output ready);
endinterface

>>> design/hed_parser.sv
// Entity parser: per request, updates the parse state and registers a
// descriptor of the bytes to emit. Depends on hed_pkg.
module hed_parser import hed_pkg::*; #(
   parameter int NAME_MAX = NAME_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       desc_take,
   output logic       desc_valid,
   output desc_type   desc,
   output logic [7:0] desc_letters [NAME_MAX]
);

   localparam int CW = $clog2(NAME_MAX + 1);
   localparam int IW = $clog2(NAME_MAX);

   localparam logic [2:0] MODE_PLAIN  = 3'd0;
   localparam logic [2:0] MODE_AMP    = 3'd1;
   localparam logic [2:0] MODE_HASH   = 3'd2;
   localparam logic [2:0] MODE_DIGITS = 3'd3;
   localparam logic [2:0] MODE_NAME   = 3'd4;

   logic [2:0]    mode_ff, mode_in, mode_upd;
   logic [31:0]   code_ff, code_in, code_upd, code_mac, code_e;
   logic [CW-1:0] count_ff, count_in, count_upd, res_cnt;
   logic [7:0]    letters_ff [NAME_MAX];
   logic [7:0]    letters_in [NAME_MAX];
   logic [7:0]    desc_letters_ff [NAME_MAX];
   logic          desc_valid_ff;
   desc_type      desc_ff, desc_in;
   logic          accept, text, resolve, known;
   logic [7:0]    known_byte;

   assign req_ready    = !desc_valid_ff || desc_take;
   assign accept       = req_valid && req_ready;
   assign desc_valid   = desc_valid_ff;
   assign desc         = desc_ff;
   assign desc_letters = desc_letters_ff;
   assign code_mac     = (code_ff << 3) + (code_ff << 1) + {28'd0, in_byte[3:0]};

   always_comb begin
      mode_upd      = mode_ff;
      code_upd      = code_ff;
      count_upd     = count_ff;
      letters_in    = letters_ff;
      res_cnt       = count_ff;
      code_e        = code_ff;
      text          = 1'b0;
      resolve       = 1'b0;
      known         = 1'b0;
      known_byte    = CH_AMP;
      desc_in       = '0;
      desc_in.tbyte = in_byte;
      desc_in.last  = in_last;
      case (mode_ff)
         MODE_AMP: begin
            if (in_byte == CH_HASH) begin
               mode_upd = MODE_HASH;
            end else if (is_letter(in_byte)) begin
               letters_in[0] = in_byte;
               count_upd     = CW'(1);
               mode_upd      = MODE_NAME;
            end else begin
               desc_in.ekind = EK_BYTE;
               desc_in.ebyte = CH_AMP;
               text          = 1'b1;
            end
         end
         MODE_HASH: begin
            if (is_digit(in_byte)) begin
               code_upd = {28'd0, in_byte[3:0]};
               mode_upd = MODE_DIGITS;
            end else begin
               desc_in.ekind = EK_AMPHASH;
               text          = 1'b1;
            end
         end
         MODE_DIGITS: begin
            if (is_digit(in_byte)) begin
               code_upd = code_mac;
            end else begin
               desc_in.ekind = EK_CODE;
               code_e        = code_ff;
               mode_upd      = MODE_PLAIN;
               text          = in_byte != CH_SEMI;
            end
         end
         MODE_NAME: begin
            if (is_letter(in_byte) && count_ff < CW'(NAME_MAX)) begin
               letters_in[count_ff[IW-1:0]] = in_byte;
               count_upd = CW'(count_ff + CW'(1));
            end else begin
               resolve   = 1'b1;
               res_cnt   = count_ff;
               count_upd = '0;
               mode_upd  = MODE_PLAIN;
               text      = in_byte != CH_SEMI;
            end
         end
         default: begin
            text = 1'b1;
         end
      endcase
      if (text) begin
         if (in_byte == CH_AMP) begin
            mode_upd = MODE_AMP;
         end else begin
            mode_upd     = MODE_PLAIN;
            desc_in.thas = 1'b1;
         end
      end
      mode_in  = mode_upd;
      code_in  = code_upd;
      count_in = count_upd;
      if (in_last) begin
         case (mode_upd)
            MODE_AMP: begin
               desc_in.thas  = 1'b1;
               desc_in.tbyte = CH_AMP;
            end
            MODE_HASH: begin
               desc_in.ekind = EK_AMPHASH;
            end
            MODE_DIGITS: begin
               desc_in.ekind = EK_CODE;
               code_e        = code_upd;
            end
            MODE_NAME: begin
               resolve = 1'b1;
               res_cnt = count_upd;
            end
            default: begin
               desc_in.thas = desc_in.thas;
            end
         endcase
         mode_in  = MODE_PLAIN;
         code_in  = '0;
         count_in = '0;
      end
      if (res_cnt == CW'(4) && letters_in[0] == "q" && letters_in[1] == "u" &&
          letters_in[2] == "o" && letters_in[3] == "t") begin
         known      = 1'b1;
         known_byte = CH_QUOT;
      end else if (res_cnt == CW'(3) && letters_in[0] == "a" && letters_in[1] == "m" &&
                   letters_in[2] == "p") begin
         known      = 1'b1;
         known_byte = CH_AMP;
      end else if (res_cnt == CW'(2) && letters_in[0] == "l" && letters_in[1] == "t") begin
         known      = 1'b1;
         known_byte = CH_LT;
      end else if (res_cnt == CW'(2) && letters_in[0] == "g" && letters_in[1] == "t") begin
         known      = 1'b1;
         known_byte = CH_GT;
      end
      if (resolve) begin
         if (known) begin
            desc_in.ekind = EK_BYTE;
            desc_in.ebyte = known_byte;
         end else begin
            desc_in.ekind = EK_ECHO;
         end
      end
      desc_in.code = code_e;
      case (desc_in.ekind)
         EK_BYTE: begin
            desc_in.elen = LEN_W'(1);
         end
         EK_AMPHASH: begin
            desc_in.elen = LEN_W'(2);
         end
         EK_CODE: begin
            desc_in.elen = LEN_W'(utf8_len(code_e));
         end
         EK_ECHO: begin
            desc_in.elen = LEN_W'(LEN_W'(res_cnt) + LEN_W'(1));
         end
         default: begin
            desc_in.elen = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PLAIN;
         code_ff       <= '0;
         count_ff      <= '0;
         desc_valid_ff <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         code_ff       <= code_in;
         count_ff      <= count_in;
         desc_valid_ff <= 1'b1;
      end else if (desc_take) begin
         desc_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         letters_ff      <= letters_in;
         desc_letters_ff <= letters_in;
         desc_ff         <= desc_in;
      end
   end

   a_count_outside_name: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_NAME |-> count_ff == '0)
      else $error("name count held outside a name");

   a_count_inside_name: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_NAME |-> count_ff != '0 && count_ff <= CW'(NAME_MAX))
      else $error("name count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> mode_ff == MODE_PLAIN && code_ff == '0)
      else $error("parse state not cleared after final request");

endmodule

>>> design/hed_serializer.sv
// Byte serializer: walks the registered descriptor one byte per unstalled cycle,
// applies the output limit and drives the response register. Depends on hed_pkg.
module hed_serializer import hed_pkg::*; #(
   parameter int NAME_MAX = NAME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        desc_valid,
   input  desc_type    desc,
   input  logic [7:0]  desc_letters [NAME_MAX],
   input  logic [15:0] limit,
   output logic        desc_take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  out_byte,
   output logic        out_valid,
   output logic        run_last,
   output logic        text_end
);

   localparam int IW = $clog2(NAME_MAX);

   logic [LEN_W-1:0] k_ff, tot, km1;
   logic [15:0]      emitted_ff, emitted_nx;
   logic             rsp_valid_ff, out_valid_ff, run_last_ff, text_end_ff;
   logic [7:0]       out_byte_ff, sel_byte;
   logic             advance, step, can_emit, is_final;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign step       = desc_valid && advance;
   assign tot        = LEN_W'(desc.elen + LEN_W'(desc.thas));
   assign km1        = LEN_W'(k_ff - LEN_W'(1));
   assign emitted_nx = 16'(emitted_ff + 16'd1);
   assign can_emit   = (emitted_ff < limit) && (k_ff < tot);
   assign is_final   = (k_ff == LEN_W'(tot - LEN_W'(1))) || (emitted_nx == limit);
   assign desc_take  = step && (!can_emit || is_final);

   assign rsp_valid = rsp_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_valid = out_valid_ff;
   assign run_last  = run_last_ff;
   assign text_end  = text_end_ff;

   always_comb begin
      sel_byte = desc.tbyte;
      if (k_ff < desc.elen) begin
         case (desc.ekind)
            EK_BYTE: begin
               sel_byte = desc.ebyte;
            end
            EK_AMPHASH: begin
               sel_byte = (k_ff == '0) ? CH_AMP : CH_HASH;
            end
            EK_CODE: begin
               sel_byte = utf8_byte(desc.code, desc.elen[2:0], k_ff[2:0]);
            end
            EK_ECHO: begin
               sel_byte = (k_ff == '0) ? CH_AMP : desc_letters[km1[IW-1:0]];
            end
            default: begin
               sel_byte = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         if (can_emit) begin
            rsp_valid_ff <= 1'b1;
            if (is_final) begin
               k_ff       <= '0;
               emitted_ff <= desc.last ? 16'd0 : emitted_nx;
            end else begin
               k_ff       <= LEN_W'(k_ff + LEN_W'(1));
               emitted_ff <= emitted_nx;
            end
         end else begin
            k_ff         <= '0;
            rsp_valid_ff <= desc.last;
            if (desc.last) begin
               emitted_ff <= '0;
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff  <= can_emit ? sel_byte : 8'd0;
         out_valid_ff <= can_emit;
         run_last_ff  <= can_emit ? is_final : 1'b1;
         text_end_ff  <= can_emit ? (is_final && desc.last) : 1'b1;
      end
   end

   a_marker_ends_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_valid_ff |-> run_last_ff && text_end_ff)
      else $error("bare marker without end flags");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && text_end_ff |-> run_last_ff)
      else $error("text end on a non-final response");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      desc_valid |-> k_ff == '0 || k_ff < tot)
      else $error("byte index past descriptor");

   a_take_rewinds: assert property (@(posedge clock) disable iff (reset)
      desc_take |=> k_ff == '0)
      else $error("byte index not rewound");

endmodule

>>> design/html_entity_to_utf8_decoder.sv
// Top level of the HTML entity to UTF-8 decoder: output limit register,
// parser and serializer. Depends on hed_pkg, hed_if, hed_parser, hed_serializer.
//
// req_chan takes one text byte per request, with in_last on the final byte of
// a text. rsp_chan returns one output byte per response; run_last marks the
// last response of a request and text_end the last of a text. A final request
// that keeps no byte returns one bare marker (out_valid 0).
// csr_chan writes output_limit, the most bytes kept per text; it is always
// ready. The user writes it only while idle; the block does not enforce this.
// Flow: a request is written to the descriptor register and its responses pass
// on to the response register; the request holds the descriptor register until
// its last response is emitted. While rsp_chan does not stall, the serializer
// emits one byte per cycle and a stream of requests with at most one response
// each runs at one per cycle. When rsp_chan stalls, the response register holds
// and req_chan ready falls once the descriptor register is also full.
// Reset: output_limit is 1024, the parser is in plain text with no pending
// entity, and no response is valid.
module html_entity_to_utf8_decoder import hed_pkg::*; #(
   parameter int NAME_MAX = NAME_MAX_DEF
) (
   input logic      clock,
   input logic      reset,
   hed_req_if.sink   req_chan,
   hed_rsp_if.source rsp_chan,
   hed_csr_if.sink   csr_chan
);

   logic [15:0] limit_ff;
   logic        desc_valid, desc_take;
   desc_type    desc;
   logic [7:0]  desc_letters [NAME_MAX];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RST;
      end else if (csr_chan.valid) begin
         limit_ff <= csr_chan.output_limit;
      end
   end

   hed_parser #(
      .NAME_MAX (NAME_MAX)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .in_byte      (req_chan.in_byte),
      .in_last      (req_chan.in_last),
      .desc_take    (desc_take),
      .desc_valid   (desc_valid),
      .desc         (desc),
      .desc_letters (desc_letters)
   );

   hed_serializer #(
      .NAME_MAX (NAME_MAX)
   ) u_serializer (
      .clock        (clock),
      .reset        (reset),
      .desc_valid   (desc_valid),
      .desc         (desc),
      .desc_letters (desc_letters),
      .limit        (limit_ff),
      .desc_take    (desc_take),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .out_byte     (rsp_chan.out_byte),
      .out_valid    (rsp_chan.out_valid),
      .run_last     (rsp_chan.run_last),
      .text_end     (rsp_chan.text_end)
   );

endmodule

>>> verif/tb_html_entity_to_utf8_decoder.sv
// Self-checking testbench of html_entity_to_utf8_decoder: random text with
// entities, an in-order prediction of the decoded bytes, random idling.
// Depends on hed_pkg, hed_if and the decoder top level from the design folder.
module tb_html_entity_to_utf8_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import hed_pkg::*;

   localparam int NAME_LEN = NAME_MAX_DEF;
   localparam int DRAIN_GUARD = 20000;

   typedef enum logic [2:0] {PM_TEXT, PM_AMP, PM_HASH, PM_DIGITS, PM_NAME} parse_mode_type;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
   } text_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       run_last;
      logic       text_end;
   } out_beat_type;

   logic clock;
   logic reset;

   hed_req_if req_chan ();
   hed_rsp_if rsp_chan ();
   hed_csr_if csr_chan ();

   html_entity_to_utf8_decoder #(.NAME_MAX(NAME_LEN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   text_req_type   text_q[$];
   logic [7:0]     text_buf[$];
   out_beat_type   pending_out[$];
   out_beat_type   step_out[$];

   parse_mode_type pm;
   logic [31:0] code_acc;
   logic [7:0]  name_buf [NAME_LEN];
   int          n_letters;
   logic [15:0] n_emitted;
   logic [15:0] limit_q;

   int send_idle_pct;
   int recv_stall_pct;
   int queued;
   int n_requests;
   int n_bytes;
   int n_markers;
   int fail_count;

   // ---------------- prediction ----------------

   function automatic bit alpha(logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
   endfunction

   function automatic bit numeral(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic void keep_byte(logic [7:0] b);
      out_beat_type r;
      if (n_emitted >= limit_q) return;
      r.out_byte  = b;
      r.out_valid = 1'b1;
      r.run_last  = 1'b0;
      r.text_end  = 1'b0;
      step_out.push_back(r);
      n_emitted++;
   endfunction

   function automatic void put_utf8(logic [31:0] u);
      int          n;
      logic [31:0] lead;
      logic [31:0] part;
      if (u[31]) begin
         if (u[7:0] != 8'd0) keep_byte(u[7:0]);
      end else if (u == 32'd0) begin
         return;
      end else if (u <= 32'h7f) begin
         keep_byte(u[7:0]);
      end else begin
         if (u <= 32'h7ff) begin
            n = 2;
            lead = 32'hc0 | (u >> 6);
         end else if (u <= 32'hffff) begin
            n = 3;
            lead = 32'he0 | (u >> 12);
         end else if (u <= 32'h1fffff) begin
            n = 4;
            lead = 32'hf0 | (u >> 18);
         end else if (u <= 32'h3ffffff) begin
            n = 5;
            lead = 32'hf8 | (u >> 24);
         end else begin
            n = 6;
            lead = 32'hfc | (u >> 30);
         end
         keep_byte(lead[7:0]);
         for (int k = n - 2; k >= 0; k--) begin
            part = u >> (6 * k);
            keep_byte(8'h80 | {2'b00, part[5:0]});
         end
      end
   endfunction

   function automatic bit name_is(string w);
      if (n_letters != w.len()) return 1'b0;
      for (int i = 0; i < w.len(); i++) begin
         if (name_buf[i] != w[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void resolve_name();
      if (name_is("quot")) begin
         keep_byte(CH_QUOT);
      end else if (name_is("amp")) begin
         keep_byte(CH_AMP);
      end else if (name_is("lt")) begin
         keep_byte(CH_LT);
      end else if (name_is("gt")) begin
         keep_byte(CH_GT);
      end else begin
         keep_byte(CH_AMP);
         for (int i = 0; i < n_letters; i++) keep_byte(name_buf[i]);
      end
      n_letters = 0;
      pm = PM_TEXT;
   endfunction

   function automatic void take_text(logic [7:0] b);
      pm = PM_TEXT;
      if (b == CH_AMP) pm = PM_AMP;
      else keep_byte(b);
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic last);
      out_beat_type r;
      step_out.delete();
      case (pm)
         PM_AMP: begin
            if (b == CH_HASH) begin
               pm = PM_HASH;
            end else if (alpha(b)) begin
               name_buf[0] = b;
               n_letters = 1;
               pm = PM_NAME;
            end else begin
               keep_byte(CH_AMP);
               take_text(b);
            end
         end
         PM_HASH: begin
            if (numeral(b)) begin
               code_acc = {24'd0, b - 8'h30};
               pm = PM_DIGITS;
            end else begin
               keep_byte(CH_AMP);
               keep_byte(CH_HASH);
               take_text(b);
            end
         end
         PM_DIGITS: begin
            if (numeral(b)) begin
               code_acc = code_acc * 32'd10 + {24'd0, b - 8'h30};
            end else begin
               put_utf8(code_acc);
               pm = PM_TEXT;
               if (b != CH_SEMI) take_text(b);
            end
         end
         PM_NAME: begin
            if (alpha(b) && n_letters < NAME_LEN) begin
               name_buf[n_letters] = b;
               n_letters++;
            end else begin
               resolve_name();
               if (b != CH_SEMI) take_text(b);
            end
         end
         default: begin
            take_text(b);
         end
      endcase
      if (last) begin
         case (pm)
            PM_AMP: begin
               keep_byte(CH_AMP);
            end
            PM_HASH: begin
               keep_byte(CH_AMP);
               keep_byte(CH_HASH);
            end
            PM_DIGITS: begin
               put_utf8(code_acc);
            end
            PM_NAME: begin
               resolve_name();
            end
            default: begin
            end
         endcase
         pm = PM_TEXT;
         code_acc = 32'd0;
         n_letters = 0;
         n_emitted = 16'd0;
         if (step_out.size() == 0) begin
            r = '0;
            step_out.push_back(r);
         end
      end
      for (int i = 0; i < step_out.size(); i++) begin
         r = step_out[i];
         if (i == step_out.size() - 1) begin
            r.run_last = 1'b1;
            r.text_end = last;
         end
         pending_out.push_back(r);
      end
   endfunction

   // ---------------- stimulus building ----------------

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic void flush_text();
      text_req_type r;
      for (int i = 0; i < text_buf.size(); i++) begin
         r.b = text_buf[i];
         r.last = (i == text_buf.size() - 1);
         text_q.push_back(r);
      end
      queued += text_buf.size();
      text_buf.delete();
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51);
      return 8'((r < 26) ? 8'h41 + r : 8'h61 + r - 26);
   endfunction

   function automatic void add_terminator();
      int         pick;
      logic [7:0] rb;
      pick = $urandom_range(9);
      if (pick < 6) begin
         text_buf.push_back(CH_SEMI);
      end else if (pick < 8) begin
         rb = 8'($urandom_range(255));
         text_buf.push_back(rb);
      end
   endfunction

   function automatic void put_digits();
      int          band;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] code;
      logic [7:0]  d;
      band = $urandom_range(8);
      case (band)
         1: begin lo = 32'h1;        hi = 32'h7f;       end
         2: begin lo = 32'h80;       hi = 32'h7ff;      end
         3: begin lo = 32'h800;      hi = 32'hffff;     end
         4: begin lo = 32'h10000;    hi = 32'h1fffff;   end
         5: begin lo = 32'h200000;   hi = 32'h3ffffff;  end
         6: begin lo = 32'h4000000;  hi = 32'h7fffffff; end
         7: begin lo = 32'h80000000; hi = 32'hffffffff; end
         default: begin lo = 32'h0;  hi = 32'h0;        end
      endcase
      if ($urandom_range(3) == 0) put_str("0");
      if (band == 8) begin
         repeat ($urandom_range(13, 11)) begin
            d = 8'(8'h30 + $urandom_range(9));
            text_buf.push_back(d);
         end
      end else begin
         case ($urandom_range(3))
            0: code = lo;
            1: code = hi;
            default: code = $urandom_range(hi, lo);
         endcase
         put_str($sformatf("%0d", code));
      end
   endfunction

   function automatic void build_text(int n_seg);
      int         pick;
      int         len;
      logic [7:0] rb;
      for (int s = 0; s < n_seg; s++) begin
         pick = $urandom_range(99);
         if (pick < 22) begin
            len = $urandom_range(3, 1);
            repeat (len) begin
               rb = 8'($urandom_range(255));
               text_buf.push_back(rb);
            end
         end else if (pick < 42) begin
            text_buf.push_back(CH_AMP);
            case ($urandom_range(3))
               0: put_str("quot");
               1: put_str("amp");
               2: put_str("lt");
               default: put_str("gt");
            endcase
            add_terminator();
         end else if (pick < 70) begin
            put_str("&#");
            put_digits();
            add_terminator();
         end else if (pick < 85) begin
            text_buf.push_back(CH_AMP);
            if ($urandom_range(3) == 0) len = NAME_LEN + $urandom_range(1);
            else len = $urandom_range(NAME_LEN + 2, 1);
            repeat (len) text_buf.push_back(rand_letter());
            add_terminator();
         end else begin
            if ($urandom_range(1) == 1) put_str("&#");
            else text_buf.push_back(CH_AMP);
            rb = 8'($urandom_range(255));
            text_buf.push_back(rb);
         end
      end
      flush_text();
   endfunction

   // ---------------- sequencing ----------------

   task automatic wait_drained();
      int guard;
      guard = 0;
      @(negedge clock);
      while ((text_q.size() != 0 || req_chan.valid || pending_out.size() != 0)
             && guard < DRAIN_GUARD) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= DRAIN_GUARD) begin
         $error("%0d expected bytes never arrived", pending_out.size());
         fail_count++;
         pending_out.delete();
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.output_limit <= v;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      limit_q = v;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin : drive_requests
      text_req_type nxt;
      logic         load;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         load = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            decode_byte(req_chan.in_byte, req_chan.in_last);
            n_requests++;
            load = 1'b1;
         end else if (!req_chan.valid) begin
            load = 1'b1;
         end
         if (load) begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = text_q.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.in_byte <= nxt.b;
               req_chan.in_last <= nxt.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      out_beat_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_out.size() == 0) begin
               $error("unexpected response: out_byte %h out_valid %b",
                      rsp_chan.out_byte, rsp_chan.out_valid);
               fail_count++;
            end else begin
               want = pending_out.pop_front();
               if (rsp_chan.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_chan.out_byte);
                  fail_count++;
               end
               if (rsp_chan.out_valid !== want.out_valid) begin
                  $error("out_valid: expected %b, got %b", want.out_valid, rsp_chan.out_valid);
                  fail_count++;
               end
               if (rsp_chan.run_last !== want.run_last) begin
                  $error("run_last: expected %b, got %b", want.run_last, rsp_chan.run_last);
                  fail_count++;
               end
               if (rsp_chan.text_end !== want.text_end) begin
                  $error("text_end: expected %b, got %b", want.text_end, rsp_chan.text_end);
                  fail_count++;
               end
               if (want.out_valid) n_bytes++;
               else n_markers++;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int limit_set [5];
      int sidle_set [5];
      int rstall_set [5];
      int target;
      bit paused;
      limit_set  = '{65535, 1, 7, 30, 1024};
      sidle_set  = '{0, 73, 0, 38, 0};
      rstall_set = '{0, 0, 73, 38, 0};
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'd0;
      req_chan.in_last = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.output_limit = 16'd0;
      pm = PM_TEXT;
      code_acc = 32'd0;
      n_letters = 0;
      n_emitted = 16'd0;
      limit_q = LIMIT_RST;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queued = 0;
      n_requests = 0;
      n_bytes = 0;
      n_markers = 0;
      fail_count = 0;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      put_str("&amp&quot;");
      flush_text();
      put_str("&lt;&#;&gt");
      flush_text();
      text_buf.push_back(8'hff);
      text_buf.push_back(CH_AMP);
      text_buf.push_back(8'h00);
      flush_text();
      put_str("&#0");
      flush_text();

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_limit(16'(limit_set[p]));
         send_idle_pct = sidle_set[p];
         recv_stall_pct = rstall_set[p];
         target = queued + 30;
         while (queued < target) begin
            build_text($urandom_range(10, 1));
            // hold the sender once until every decoded byte is back
            if (p == 1 && !paused && queued >= target - 15) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end
      wait_drained();

      $display("Checked %0d requests: %0d decoded bytes and %0d end markers",
               n_requests, n_bytes, n_markers);
      $display("Output limits 1024, 65535, 1, 7, 30, 1024; idling up to 73 percent per side");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/hed_pkg.sv
design/hed_if.sv
design/hed_parser.sv
design/hed_serializer.sv
design/html_entity_to_utf8_decoder.sv
verif/tb_html_entity_to_utf8_decoder.sv
